@@ rtl/core/crp_pkg.sv @@
package crp_pkg;

  // Store geometry.
  localparam int unsigned ImgMax    = 32;
  localparam int unsigned ImgAw     = $clog2(ImgMax);
  localparam int unsigned ImgDepth  = ImgMax * ImgMax;
  localparam int unsigned KernDepth = 49;
  localparam int unsigned OutDepth  = 64;

  localparam logic [5:0]  KernIdxEnd = 6'd49;
  localparam logic [2:0]  PoolMax    = 3'd4;
  localparam logic [5:0]  ImgSide    = 6'd32;
  localparam logic [6:0]  RunMax     = 7'd34;
  localparam logic [14:0] FeatSat    = 15'h7fff;

  // Reciprocal of nine, exact for sums below 2**20 after a shift of 22.
  localparam logic [18:0] Div9Mul    = 19'd466034;

  typedef enum logic [2:0] {
    REG_KERNEL_SIZE = 3'd0,
    REG_CONV_STRIDE = 3'd1,
    REG_PAD_ENABLE  = 3'd2,
    REG_POOL_MODE   = 3'd3,
    REG_POOL_SIZE   = 3'd4,
    REG_IMAGE_SIZE  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_SKIP  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PIXEL = 2'd2
  } op_kind_e;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_ROWS,
    ENG_COLS,
    ENG_MAC,
    ENG_DRAIN,
    ENG_RELEASE
  } eng_state_e;

  typedef struct packed {
    op_kind_e           kind;
    logic [5:0]         idx;
    logic signed [15:0] value;
  } op_t;

  // Effective register values, already clamped to their legal ranges.
  typedef struct packed {
    logic [2:0] k;
    logic [2:0] st;
    logic       pad;
    logic       avg;
    logic [2:0] ps;
    logic [5:0] img;
  } cfg_t;

  typedef struct packed {
    logic [14:0] feature;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        last_img;
  } feat_t;

  typedef struct packed {
    logic  push;
    feat_t data;
    logic  release_run;
  } oq_ctrl_t;

endpackage

@@ rtl/core/crp_stream_if.sv @@
interface crp_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [5:0]         kernel_index;
  logic signed [15:0] data_value;

  modport source (output valid, command, kernel_index, data_value, input ready);
  modport sink (input valid, command, kernel_index, data_value, output ready);
endinterface

interface crp_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] feature;
  logic [5:0]  out_row;
  logic [5:0]  out_col;
  logic        last_of_run;
  logic        last_of_image;

  modport source (output valid, feature, out_row, out_col, last_of_run, last_of_image,
                  input ready);
  modport sink (input valid, feature, out_row, out_col, last_of_run, last_of_image,
                output ready);
endinterface

@@ rtl/core/crp_front.sv @@
module crp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  crp_in_if.sink        item_i,
  output crp_pkg::op_t  op_o,
  output logic          op_valid_o,
  input  logic          op_ready_i
);
  import crp_pkg::*;

  op_t        ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  op_t        op_new;

  // Loads beyond the kernel store are turned into no-ops here.
  always_comb begin
    op_new.idx   = item_i.kernel_index;
    op_new.value = item_i.data_value;
    if (item_i.command) begin
      op_new.kind = OP_PIXEL;
    end else if (item_i.kernel_index < KernIdxEnd) begin
      op_new.kind = OP_LOAD;
    end else begin
      op_new.kind = OP_SKIP;
    end
  end

  assign item_i.ready = (cnt_q != 2'd2);
  assign push         = item_i.valid && item_i.ready;
  assign op_valid_o   = (cnt_q != 2'd0);
  assign pop          = op_valid_o && op_ready_i;
  assign op_o         = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= op_new;
  end

endmodule

@@ rtl/core/crp_engine.sv @@
module crp_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crp_pkg::cfg_t     cfg_i,
  input  crp_pkg::op_t      op_i,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  output crp_pkg::oq_ctrl_t oq_ctrl_o,
  input  logic              oq_pending_i
);
  import crp_pkg::*;

  eng_state_e state_q, state_d;

  // Stores.
  logic signed [15:0] img_mem [ImgDepth];
  logic signed [15:0] kern_mem [KernDepth];
  logic signed [15:0] pix_rd_q, kern_rd_q;

  // Geometry derived from the registers.
  logic [2:0] kl, pl;
  logic [6:0] fr, fr_m1, d_c, o_c, pad7, img7;

  // Pixel position and the framed range that the current pixel passes.
  logic [5:0] pr_q, pc_q;
  logic [5:0] r_c, c_c, r_nx, c_nx;
  logic [6:0] cur_y, cur_x;
  logic [6:0] prev_y_q, prev_x_q, hi_y_q, hi_x_q;
  logic       prev_none_q;

  // Scan over the pooled map.
  logic [5:0] a_q, b_q;
  logic [6:0] yb_q, xb_q, y_now, x_now;
  logic       in_range, last_img_q;

  // Tap sequencer.
  logic [2:0] i_q, j_q, u_q, v_q;
  logic [5:0] kidx_q;
  logic [6:0] cy_q, cx_q, fy, fx, iy, ix;
  logic       tap_zero, tap_final;

  // Strobes from the state machine.
  logic pix_go, kern_we, row_skip, row_enter, col_skip, feat_start, tap_issue, release_run;

  // Multiply-accumulate pipeline.
  logic               v1_q, first1_q, last1_q, lastp1_q, zero1_q;
  logic               v2_q, first2_q, last2_q, lastp2_q;
  logic signed [31:0] prod_c, prod_q;
  logic signed [37:0] acc_q;
  logic               accv_q, lastp3_q;
  logic [29:0]        acc_sh;
  logic [14:0]        conv_c;
  logic [14:0]        best_q;
  logic [18:0]        total_q;
  logic               pooldone_q;
  logic               fin_v_q, fin_sel3_q;
  logic [14:0]        fin_val_q, pool_c;
  logic [37:0]        fin_prod_q;

  assign kl    = cfg_i.k - 3'd1;
  assign pl    = cfg_i.ps - 3'd1;
  assign pad7  = {6'd0, cfg_i.pad};
  assign img7  = {1'b0, cfg_i.img};
  assign fr    = img7 + {5'd0, cfg_i.pad, 1'b0};
  assign fr_m1 = fr - 7'd1;
  assign d_c   = 7'(cfg_i.ps) * 7'(cfg_i.st);
  assign o_c   = 7'(pl) * 7'(cfg_i.st) + 7'(kl);

  // A position outside the current image side restarts the image.
  always_comb begin
    if (pr_q >= cfg_i.img || pc_q >= cfg_i.img) begin
      r_c = 6'd0;
      c_c = 6'd0;
    end else begin
      r_c = pr_q;
      c_c = pc_q;
    end
    cur_y = 7'(r_c) + pad7;
    cur_x = 7'(c_c) + pad7;
    if (c_c + 6'd1 >= cfg_i.img) begin
      c_nx = 6'd0;
      r_nx = (r_c + 6'd1 >= cfg_i.img) ? 6'd0 : r_c + 6'd1;
    end else begin
      c_nx = c_c + 6'd1;
      r_nx = r_c;
    end
  end

  assign y_now    = yb_q + o_c;
  assign x_now    = xb_q + o_c;
  assign in_range = (prev_none_q || y_now > prev_y_q || (y_now == prev_y_q && x_now > prev_x_q))
                 && (y_now < hi_y_q || (y_now == hi_y_q && x_now <= hi_x_q));

  assign fy        = cy_q + 7'(u_q);
  assign fx        = cx_q + 7'(v_q);
  assign iy        = fy - pad7;
  assign ix        = fx - pad7;
  assign tap_zero  = (fy < pad7) || (fx < pad7) || (iy >= img7) || (ix >= img7);
  assign tap_final = (v_q == kl) && (u_q == kl) && (j_q == pl) && (i_q == pl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_ready_o  = 1'b0;
    pix_go      = 1'b0;
    kern_we     = 1'b0;
    row_skip    = 1'b0;
    row_enter   = 1'b0;
    col_skip    = 1'b0;
    feat_start  = 1'b0;
    tap_issue   = 1'b0;
    release_run = 1'b0;
    unique case (state_q)
      ENG_IDLE: begin
        if (op_valid_i && !oq_pending_i) begin
          op_ready_o = 1'b1;
          unique case (op_i.kind)
            OP_PIXEL: begin
              pix_go  = 1'b1;
              state_d = ENG_ROWS;
            end
            OP_LOAD: begin
              kern_we = 1'b1;
              state_d = ENG_RELEASE;
            end
            default: begin
              state_d = ENG_RELEASE;
            end
          endcase
        end
      end
      ENG_ROWS: begin
        if (y_now > fr_m1 || y_now > hi_y_q) begin
          state_d = ENG_RELEASE;
        end else if (!prev_none_q && y_now < prev_y_q) begin
          row_skip = 1'b1;
        end else begin
          row_enter = 1'b1;
          state_d   = ENG_COLS;
        end
      end
      ENG_COLS: begin
        if (x_now > fr_m1) begin
          row_skip = 1'b1;
          state_d  = ENG_ROWS;
        end else if (in_range) begin
          feat_start = 1'b1;
          state_d    = ENG_MAC;
        end else begin
          col_skip = 1'b1;
        end
      end
      ENG_MAC: begin
        tap_issue = 1'b1;
        if (tap_final) state_d = ENG_DRAIN;
      end
      ENG_DRAIN: begin
        if (fin_v_q) begin
          col_skip = 1'b1;
          state_d  = ENG_COLS;
        end
      end
      ENG_RELEASE: begin
        release_run = 1'b1;
        state_d     = ENG_IDLE;
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_q <= 6'd0;
      pc_q <= 6'd0;
    end else if (pix_go) begin
      pr_q <= r_nx;
      pc_q <= c_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_go) begin
      if (c_c != 6'd0) begin
        prev_none_q <= 1'b0;
        prev_y_q    <= cur_y;
        prev_x_q    <= cur_x - 7'd1;
      end else if (r_c != 6'd0) begin
        prev_none_q <= 1'b0;
        prev_y_q    <= cur_y - 7'd1;
        prev_x_q    <= img7 - 7'd1 + pad7;
      end else begin
        prev_none_q <= 1'b1;
        prev_y_q    <= 7'd0;
        prev_x_q    <= 7'd0;
      end
      if (r_c == cfg_i.img - 6'd1 && c_c == cfg_i.img - 6'd1) begin
        hi_y_q <= fr_m1;
        hi_x_q <= fr_m1;
      end else begin
        hi_y_q <= cur_y;
        hi_x_q <= cur_x;
      end
      a_q  <= 6'd0;
      yb_q <= 7'd0;
    end
    if (row_skip) begin
      a_q  <= a_q + 6'd1;
      yb_q <= yb_q + d_c;
    end
    if (row_enter) begin
      b_q  <= 6'd0;
      xb_q <= 7'd0;
    end
    if (col_skip) begin
      b_q  <= b_q + 6'd1;
      xb_q <= xb_q + d_c;
    end
    if (feat_start) begin
      i_q        <= 3'd0;
      j_q        <= 3'd0;
      u_q        <= 3'd0;
      v_q        <= 3'd0;
      kidx_q     <= 6'd0;
      cy_q       <= yb_q;
      cx_q       <= xb_q;
      last_img_q <= (y_now + d_c > fr_m1) && (x_now + d_c > fr_m1);
    end
    if (tap_issue) begin
      if (v_q != kl) begin
        v_q    <= v_q + 3'd1;
        kidx_q <= kidx_q + 6'd1;
      end else begin
        v_q <= 3'd0;
        if (u_q != kl) begin
          u_q    <= u_q + 3'd1;
          kidx_q <= kidx_q + 6'd1;
        end else begin
          u_q    <= 3'd0;
          kidx_q <= 6'd0;
          if (j_q != pl) begin
            j_q  <= j_q + 3'd1;
            cx_q <= cx_q + 7'(cfg_i.st);
          end else begin
            j_q  <= 3'd0;
            cx_q <= xb_q;
            i_q  <= i_q + 3'd1;
            cy_q <= cy_q + 7'(cfg_i.st);
          end
        end
      end
    end
  end

  // Image and kernel stores, one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (pix_go) img_mem[{r_c[ImgAw-1:0], c_c[ImgAw-1:0]}] <= op_i.value;
    pix_rd_q <= img_mem[{iy[ImgAw-1:0], ix[ImgAw-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (kern_we) kern_mem[op_i.idx] <= op_i.value;
    kern_rd_q <= kern_mem[kidx_q];
  end

  assign prod_c = pix_rd_q * kern_rd_q;
  assign acc_sh = acc_q[37:8];
  assign conv_c = (acc_q <= 38'sd0) ? 15'd0 : ((|acc_sh[29:15]) ? FeatSat : acc_sh[14:0]);

  always_comb begin
    if (!cfg_i.avg) begin
      pool_c = best_q;
    end else begin
      unique case (cfg_i.ps)
        3'd2:    pool_c = total_q[16:2];
        3'd4:    pool_c = total_q[18:4];
        default: pool_c = total_q[14:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      accv_q     <= 1'b0;
      pooldone_q <= 1'b0;
      fin_v_q    <= 1'b0;
    end else begin
      v1_q       <= tap_issue;
      v2_q       <= v1_q;
      accv_q     <= v2_q && last2_q;
      pooldone_q <= accv_q && lastp3_q;
      fin_v_q    <= pooldone_q;
    end
  end

  always_ff @(posedge clk_i) begin
    first1_q <= (u_q == 3'd0) && (v_q == 3'd0);
    last1_q  <= (u_q == kl) && (v_q == kl);
    lastp1_q <= tap_final;
    zero1_q  <= tap_zero;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    lastp2_q <= lastp1_q;
    prod_q   <= zero1_q ? 32'sd0 : prod_c;
    if (v2_q) begin
      acc_q    <= first2_q ? 38'(prod_q) : acc_q + 38'(prod_q);
      lastp3_q <= lastp2_q;
    end
    if (feat_start) begin
      best_q  <= 15'd0;
      total_q <= 19'd0;
    end else if (accv_q) begin
      if (conv_c > best_q) best_q <= conv_c;
      total_q <= total_q + 19'(conv_c);
    end
    fin_sel3_q <= cfg_i.avg && (cfg_i.ps == 3'd3);
    fin_val_q  <= pool_c;
    fin_prod_q <= 38'(total_q) * 38'(Div9Mul);
  end

  always_comb begin
    oq_ctrl_o.push          = fin_v_q;
    oq_ctrl_o.data.feature  = fin_sel3_q ? fin_prod_q[36:22] : fin_val_q;
    oq_ctrl_o.data.row      = a_q;
    oq_ctrl_o.data.col      = b_q;
    oq_ctrl_o.data.last_img = last_img_q;
    oq_ctrl_o.release_run   = release_run;
  end

endmodule

@@ rtl/core/crp_out_fifo.sv @@
module crp_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crp_pkg::oq_ctrl_t ctrl_i,
  output logic              pending_o,
  crp_out_if.source         feat_o
);
  import crp_pkg::*;

  localparam int unsigned Aw = $clog2(OutDepth);

  feat_t         mem [OutDepth];
  feat_t         rd_q;
  logic [Aw-1:0] head_q, head_d, tail_q;
  logic [Aw:0]   cnt_q;
  logic [5:0]    rel_q;
  logic          push_ok, pop;

  assign push_ok   = ctrl_i.push && (cnt_q != (Aw+1)'(OutDepth));
  assign pop       = feat_o.valid && feat_o.ready;
  assign head_d    = pop ? head_q + 1'b1 : head_q;
  assign pending_o = (rel_q != 6'd0);

  // Features become visible only once the whole run of an item is released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
      rel_q  <= 6'd0;
    end else begin
      head_q <= head_d;
      if (push_ok) tail_q <= tail_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_ok) - (Aw+1)'(pop);
      if (ctrl_i.release_run) begin
        rel_q <= (cnt_q > RunMax) ? RunMax[5:0] : cnt_q[5:0];
      end else if (pop) begin
        rel_q <= rel_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) mem[tail_q] <= ctrl_i.data;
    rd_q <= mem[head_d];
  end

  assign feat_o.valid         = (rel_q != 6'd0);
  assign feat_o.feature       = rd_q.feature;
  assign feat_o.out_row       = rd_q.row;
  assign feat_o.out_col       = rd_q.col;
  assign feat_o.last_of_image = rd_q.last_img;
  assign feat_o.last_of_run   = (rel_q == 6'd1);

endmodule

@@ rtl/core/conv2d_relu_pool_layer_core.sv @@
// One convolution, ReLU and pooling layer over a square image of up to 32 x 32 signed Q8.8
// pixels that arrive in raster order, after the kernel coefficients have been loaded by load
// beats. Each input beat (load or pixel) is taken into a two-entry command queue and then
// carried out by a single multiply-accumulate engine, one kernel tap per cycle, reading one
// image pixel and one coefficient from its stores each cycle. A pixel beat costs a scan
// over the pooled map rows, plus a scan over the columns of each pooled row that the pixel
// completes, plus, for each pooled feature it completes, the pool side squared times the
// kernel side squared in taps and a pipeline drain. The features that a beat completes are
// then released together, at most 34 per beat, and are delivered in raster order of the
// pooled map; the next command starts once that run has been taken. The stores need no
// clearing pass after reset. Registers are written over an APB-style port at byte address
// 4*i and should only change while the block is idle.
module conv2d_relu_pool_layer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  crp_in_if.sink      item_i,
  crp_out_if.source   feat_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import crp_pkg::*;

  // Raw register values as written.
  logic [2:0] ksize_q, stride_q, psize_q;
  logic       pad_q, pmode_q;
  logic [5:0] isize_q;

  cfg_t     cfg;
  op_t      op;
  logic     op_valid, op_ready;
  oq_ctrl_t oq_ctrl;
  logic     oq_pending;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q  <= 3'd3;
      stride_q <= 3'd1;
      pad_q    <= 1'b0;
      pmode_q  <= 1'b0;
      psize_q  <= 3'd2;
      isize_q  <= 6'd28;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KERNEL_SIZE: ksize_q  <= pwdata[2:0];
        REG_CONV_STRIDE: stride_q <= pwdata[2:0];
        REG_PAD_ENABLE:  pad_q    <= pwdata[0];
        REG_POOL_MODE:   pmode_q  <= pwdata[0];
        REG_POOL_SIZE:   psize_q  <= pwdata[2:0];
        REG_IMAGE_SIZE:  isize_q  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KERNEL_SIZE: prdata = {29'd0, ksize_q};
      REG_CONV_STRIDE: prdata = {29'd0, stride_q};
      REG_PAD_ENABLE:  prdata = {31'd0, pad_q};
      REG_POOL_MODE:   prdata = {31'd0, pmode_q};
      REG_POOL_SIZE:   prdata = {29'd0, psize_q};
      REG_IMAGE_SIZE:  prdata = {26'd0, isize_q};
      default:         prdata = 32'd0;
    endcase
  end

  // A zero side or step acts as one; pool and image sides saturate at their maxima.
  always_comb begin
    cfg.k   = (ksize_q == 3'd0) ? 3'd1 : ksize_q;
    cfg.st  = (stride_q == 3'd0) ? 3'd1 : stride_q;
    cfg.pad = pad_q;
    cfg.avg = pmode_q;
    if (psize_q == 3'd0) begin
      cfg.ps = 3'd1;
    end else if (psize_q > PoolMax) begin
      cfg.ps = PoolMax;
    end else begin
      cfg.ps = psize_q;
    end
    if (isize_q == 6'd0) begin
      cfg.img = 6'd1;
    end else if (isize_q > ImgSide) begin
      cfg.img = ImgSide;
    end else begin
      cfg.img = isize_q;
    end
  end

  crp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .op_o       (op),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready)
  );

  crp_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .op_i         (op),
    .op_valid_i   (op_valid),
    .op_ready_o   (op_ready),
    .oq_ctrl_o    (oq_ctrl),
    .oq_pending_i (oq_pending)
  );

  crp_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (oq_ctrl),
    .pending_o (oq_pending),
    .feat_o    (feat_o)
  );

endmodule

@@ rtl/core/crp_checker.sv @@
module crp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [14:0] feature_i,
  input logic [5:0]  out_row_i,
  input logic [5:0]  out_col_i,
  input logic        last_of_run_i,
  input logic        last_of_image_i
);

  // A stalled beat is neither withdrawn nor altered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable({feature_i, out_row_i, out_col_i, last_of_run_i, last_of_image_i}))
    else $error("result beat changed while stalled");

  // The pooled map is square, so its final feature lies on the diagonal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_of_image_i |-> out_row_i == out_col_i)
    else $error("last feature of image off the diagonal");

  // A run ends with its marked beat; the next run needs the engine to release it first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_of_run_i |=> !out_valid_i)
    else $error("result beat straight after the end of a run");

endmodule

bind conv2d_relu_pool_layer_core crp_checker u_crp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (feat_o.valid),
  .out_ready_i     (feat_o.ready),
  .feature_i       (feat_o.feature),
  .out_row_i       (feat_o.out_row),
  .out_col_i       (feat_o.out_col),
  .last_of_run_i   (feat_o.last_of_run),
  .last_of_image_i (feat_o.last_of_image)
);

@@ tb/conv2d_relu_pool_layer_checker.sv @@
// Watches the item and feature channels and the register port, keeps its own copy of the
// layer state and predicts every pooled feature that each accepted item releases.
module conv2d_relu_pool_layer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  crp_in_if           item_mon,
  crp_out_if          feat_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatches,
  output int unsigned pending
);
  import crp_pkg::*;

  typedef struct {
    logic [14:0] feature;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        run_end;
    logic        img_end;
  } feat_beat_t;

  logic [2:0] k_reg, st_reg, ps_reg;
  logic       pad_reg, avg_reg;
  logic [5:0] img_reg;

  logic signed [15:0] coeffs [KernDepth];
  logic signed [15:0] pixels [ImgDepth];
  int unsigned        pix_row, pix_col;

  feat_beat_t backlog [$];
  feat_beat_t awaited [$];

  function automatic int unsigned side_k();
    return (k_reg == 0) ? 1 : k_reg;
  endfunction

  function automatic int unsigned side_st();
    return (st_reg == 0) ? 1 : st_reg;
  endfunction

  function automatic int unsigned side_ps();
    if (ps_reg == 0) return 1;
    return (ps_reg > PoolMax) ? PoolMax : ps_reg;
  endfunction

  function automatic int unsigned side_img();
    if (img_reg == 0) return 1;
    return (img_reg > ImgSide) ? ImgSide : img_reg;
  endfunction

  function automatic longint framed(int unsigned y, int unsigned x, int unsigned s,
                                    int unsigned p);
    if (y < p || x < p) return 0;
    if (y - p >= s || x - p >= s) return 0;
    return pixels[(y - p) * ImgMax + (x - p)];
  endfunction

  // Dot product of one window, cut to Q8.8, ReLU and saturation.
  function automatic int unsigned conv_value(int unsigned cr, int unsigned cc);
    longint      acc;
    int unsigned k, st, s, p;
    k   = side_k();
    st  = side_st();
    s   = side_img();
    p   = pad_reg;
    acc = 0;
    for (int i = 0; i < k; i++) begin
      for (int j = 0; j < k; j++) begin
        acc += framed(cr * st + i, cc * st + j, s, p) * longint'(coeffs[i * k + j]);
      end
    end
    if (acc <= 0) return 0;
    acc = acc >>> 8;
    return (acc > FeatSat) ? FeatSat : int'(acc);
  endfunction

  function automatic int unsigned pooled_value(int unsigned a, int unsigned b);
    int unsigned ps, best, total, c;
    ps    = side_ps();
    best  = 0;
    total = 0;
    for (int i = 0; i < ps; i++) begin
      for (int j = 0; j < ps; j++) begin
        c = conv_value(a * ps + i, b * ps + j);
        if (c > best) best = c;
        total += c;
      end
    end
    return avg_reg ? total / (ps * ps) : best;
  endfunction

  task automatic take_item(logic cmd, logic [5:0] idx, logic signed [15:0] val);
    int unsigned s, p, k, st, ps, fr, cmap, qmap, n;
    longint      cur, prev, hi, y, x, due;
    feat_beat_t  fb;
    if (!cmd) begin
      if (idx < KernIdxEnd) coeffs[idx] = val;
    end else begin
      s  = side_img();
      p  = pad_reg;
      k  = side_k();
      st = side_st();
      ps = side_ps();
      fr = s + 2 * p;
      if (pix_row >= s || pix_col >= s) begin
        pix_row = 0;
        pix_col = 0;
      end
      pixels[pix_row * ImgMax + pix_col] = val;
      cur = longint'(pix_row + p) * fr + (pix_col + p);
      if (pix_col > 0) prev = cur - 1;
      else if (pix_row > 0) prev = longint'(pix_row - 1 + p) * fr + (s - 1 + p);
      else prev = -1;
      hi   = (pix_row == s - 1 && pix_col == s - 1) ? longint'(fr) * fr - 1 : cur;
      cmap = (fr >= k) ? (fr - k) / st + 1 : 0;
      qmap = (cmap >= ps) ? cmap / ps : 0;
      for (int a = 0; a < qmap; a++) begin
        for (int b = 0; b < qmap; b++) begin
          y   = longint'(a * ps + ps - 1) * st + k - 1;
          x   = longint'(b * ps + ps - 1) * st + k - 1;
          due = y * fr + x;
          if (due > prev && due <= hi && backlog.size() < OutDepth) begin
            fb.feature = 15'(pooled_value(a, b));
            fb.row     = 6'(a);
            fb.col     = 6'(b);
            fb.run_end = 1'b0;
            fb.img_end = (a == qmap - 1 && b == qmap - 1);
            backlog    = {backlog, fb};
          end
        end
      end
      pix_col++;
      if (pix_col >= s) begin
        pix_col = 0;
        pix_row++;
        if (pix_row >= s) pix_row = 0;
      end
    end
    // At most one run of features leaves per item; the rest waits for later items.
    n = 0;
    while (backlog.size() > 0 && n < RunMax) begin
      fb = backlog.pop_front();
      fb.run_end = (backlog.size() == 0 || n + 1 == RunMax);
      awaited = {awaited, fb};
      n++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    feat_beat_t want;
    if (!rst_ni) begin
      k_reg      = 3'd3;
      st_reg     = 3'd1;
      pad_reg    = 1'b0;
      avg_reg    = 1'b0;
      ps_reg     = 3'd2;
      img_reg    = 6'd28;
      pix_row    = 0;
      pix_col    = 0;
      mismatches = 0;
      backlog.delete();
      awaited.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_KERNEL_SIZE: k_reg   = pwdata[2:0];
          REG_CONV_STRIDE: st_reg  = pwdata[2:0];
          REG_PAD_ENABLE:  pad_reg = pwdata[0];
          REG_POOL_MODE:   avg_reg = pwdata[0];
          REG_POOL_SIZE:   ps_reg  = pwdata[2:0];
          REG_IMAGE_SIZE:  img_reg = pwdata[5:0];
          default: ;
        endcase
      end
      if (item_mon.valid && item_mon.ready) begin
        take_item(item_mon.command, item_mon.kernel_index, item_mon.data_value);
      end
      if (feat_mon.valid && feat_mon.ready) begin
        if (awaited.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected feature beat: expected none, actual %0d row %0d col %0d",
                   $time, feat_mon.feature, feat_mon.out_row, feat_mon.out_col);
        end else begin
          want = awaited.pop_front();
          if (want.feature !== feat_mon.feature || want.row !== feat_mon.out_row ||
              want.col !== feat_mon.out_col || want.run_end !== feat_mon.last_of_run ||
              want.img_end !== feat_mon.last_of_image) begin
            mismatches++;
            $display("%0t: feature mismatch: expected %0d r%0d c%0d run %0b img %0b,",
                     $time, want.feature, want.row, want.col, want.run_end, want.img_end);
            $display("%0t:   actual %0d r%0d c%0d run %0b img %0b", $time,
                     feat_mon.feature, feat_mon.out_row, feat_mon.out_col,
                     feat_mon.last_of_run, feat_mon.last_of_image);
          end
        end
      end
    end
    pending = awaited.size();
  end

endmodule

@@ tb/conv2d_relu_pool_layer_core_tb.sv @@
// Top of the testbench for the conv-ReLU-pool layer. It makes the clock and the reset,
// drives item beats and register writes, throttles the feature channel and gives the
// verdict. All prediction and comparison lives in the checker instantiated beside the block.
module conv2d_relu_pool_layer_core_tb;
  import crp_pkg::*;

  // The slowest correct run, with every stall at its longest, stays well below this.
  localparam int unsigned CycleLimit = 3000000;
  // The largest feature runs every tap of the largest pool and kernel plus a scan; this covers a block still busy
  // with an item that releases nothing.
  localparam int unsigned SettleCycles = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  int unsigned mismatches, pending;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned stall_left;
  bit          idle_on;

  crp_in_if  item_ch ();
  crp_out_if feat_ch ();

  conv2d_relu_pool_layer_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .feat_o  (feat_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  conv2d_relu_pool_layer_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_mon   (item_ch),
    .feat_mon   (feat_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // A watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The feature sink now and then drops ready for a random burst, unless idling is switched off.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) feat_ch.ready = 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      feat_ch.ready = 1'b0;
      stall_left    = $urandom_range(1, 13);
    end
  end

  // Pixels mostly of a modest size so that sums neither saturate nor vanish, with a
  // quarter drawn over the whole Q8.8 range.
  function automatic logic signed [15:0] pick_pixel();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 16'hffff));
    return 16'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  function automatic logic signed [15:0] pick_coeff();
    if ($urandom_range(0, 7) == 0) return 16'($urandom_range(0, 16'hffff));
    return 16'($signed($urandom_range(0, 511)) - 256);
  endfunction

  // One item beat, held until the block takes it. A random gap may come before it.
  task automatic send_item(logic cmd, logic [5:0] idx, logic signed [15:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    item_ch.valid        = 1'b1;
    item_ch.command      = cmd;
    item_ch.kernel_index = idx;
    item_ch.data_value   = val;
    do @(posedge clk_i); while (!item_ch.ready);
    @(negedge clk_i);
    item_ch.valid = 1'b0;
    items_sent++;
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Registers only change once the block has drained and settled.
  task automatic wait_quiet();
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One phase: new register values, a fresh kernel for the new side, then whole images.
  // Ignored loads (index past the store) are sprinkled among the pixels as noise.
  task automatic run_phase(logic [2:0] k, logic [2:0] st, logic pad, logic avg,
                           logic [2:0] ps, logic [5:0] img, int unsigned images);
    int unsigned side_k, side_i;
    wait_quiet();
    reg_write(REG_KERNEL_SIZE, 32'(k));
    reg_write(REG_CONV_STRIDE, 32'(st));
    reg_write(REG_PAD_ENABLE, 32'(pad));
    reg_write(REG_POOL_MODE, 32'(avg));
    reg_write(REG_POOL_SIZE, 32'(ps));
    reg_write(REG_IMAGE_SIZE, 32'(img));
    side_k = (k == 0) ? 1 : k;
    side_i = (img == 0) ? 1 : ((img > ImgSide) ? ImgSide : img);
    for (int i = 0; i < side_k * side_k; i++) send_item(1'b0, 6'(i), pick_coeff());
    for (int n = 0; n < images; n++) begin
      for (int i = 0; i < side_i * side_i; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(1'b0, 6'($urandom_range(KernIdxEnd, 63)), pick_coeff());
        end
        send_item(1'b1, 6'($urandom_range(0, 63)), pick_pixel());
      end
    end
  endtask

  initial begin
    logic signed [15:0] edge_vals [4];
    edge_vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
    rst_ni               = 1'b0;
    cycles               = 0;
    items_sent           = 0;
    stall_left           = 0;
    idle_on              = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    item_ch.valid        = 1'b0;
    item_ch.command      = 1'b0;
    item_ch.kernel_index = '0;
    item_ch.data_value   = '0;
    feat_ch.ready        = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening: a 3x3 kernel holding the extreme coefficients, the two ignored
    // indices at their range ends, and a 4x4 image: extreme and sign-edge pixels, then 1.0.
    reg_write(REG_IMAGE_SIZE, 32'd4);
    for (int i = 0; i < 9; i++) send_item(1'b0, 6'(i), edge_vals[i % 4]);
    send_item(1'b0, KernIdxEnd, 16'sh7fff);
    send_item(1'b0, 6'd63, 16'sh8000);
    for (int i = 0; i < 16; i++) begin
      send_item(1'b1, 6'd0, (i < 8) ? edge_vals[i % 4] : 16'sh0100);
      // Half-way through, the sender holds off until every feature so far has arrived.
      if (i == 7) while (pending != 0) @(negedge clk_i);
    end

    // Register extremes: the largest kernel and stride with a border and averaging, then
    // zero written to every side register (each acting as one), then an oversized pool side.
    run_phase(3'd7, 3'd7, 1'b1, 1'b1, 3'd1, 6'd9, 1);
    run_phase(3'd0, 3'd0, 1'b0, 1'b0, 3'd0, 6'd0, 3);
    run_phase(3'd2, 3'd1, 1'b1, 1'b1, 3'd7, 6'd10, 1);

    // Random part: mostly small images so the run stays short.
    while (items_sent < 300) begin
      run_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                3'($urandom_range(0, 7)), 6'($urandom_range(0, 10)),
                $urandom_range(1, 2));
    end

    // Largest image with a border and one-by-one windows: its first pixel releases the
    // whole top border row and more, so one run is full and the rest spills onto the
    // second pixel. The image is then cut short by shrinking the side to one, which
    // restarts the position, and a single pixel completes that small image.
    run_phase(3'd1, 3'd1, 1'b1, 1'b0, 3'd1, 6'd63, 0);
    send_item(1'b1, 6'd0, pick_pixel());
    send_item(1'b1, 6'd0, pick_pixel());
    wait_quiet();
    reg_write(REG_IMAGE_SIZE, 32'd1);
    send_item(1'b1, 6'd0, pick_pixel());

    // Closing stretch with no idling on either side.
    wait_quiet();
    idle_on = 1'b0;
    run_phase(3'd3, 3'd1, 1'b1, 1'b1, 3'd2, 6'd6, 2);

    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
